/* rtl/core/avr_pkg.sv */
// Package for the axis-angle vector rotator: field widths, pipeline stage
// numbers, CORDIC arctangent table and the output saturation helper.
// Depends on nothing.
package avr_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int SAMPLE_WIDTH  = 16;
  localparam int OUT_W = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;

  localparam int FLD_W  = 16;
  localparam int IN_W   = 7 * FLD_W;
  localparam int OUT_DW = 3 * FLD_W;

  // axis length: floor(sqrt(sum << 16)), one result bit per stage
  localparam int SUM_W = 2 * FLD_W;
  localparam int N_W   = SUM_W + 16;
  localparam int NSQ   = N_W / 2;
  localparam int LEN_W = NSQ;

  // unit component (|a| << 38) / len never exceeds 2^30: 31 quotient bits
  localparam int UNIT_SH = 38;
  localparam int NDV     = 31;
  localparam int DV_PRE  = UNIT_SH - NDV;

  localparam int CS_W = 32;
  localparam int PQ_W = 2 * CS_W;
  localparam int PT_W = CS_W + FLD_W;
  localparam int T_W  = 28;
  localparam int ST_W = PT_W + 2;
  localparam int PR_W = T_W + CS_W;
  localparam int SR_W = PR_W + 2;
  localparam int R_W  = 24;

  localparam logic signed [CS_W-1:0] INV_GAIN = 32'sd652032874;
  localparam logic signed [CS_W-1:0] QUARTER  = 32'sd1073741824;

  localparam logic signed [CS_W-1:0] ATAN_TBL [24] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41721,     32'sd20860,
    32'sd10430,     32'sd5215,      32'sd2607,      32'sd1303,
    32'sd651,       32'sd325,       32'sd162,       32'sd81
  };

  // stage numbers, stage 0 is the input register
  localparam int ST_CS = CORDIC_STAGES + 2;
  localparam int ST_DV = 1 + NSQ + NDV;
  localparam int ST_M1 = ST_DV + 1;
  localparam int ST_Q  = ST_M1 + 1;
  localparam int ST_T1 = ST_Q + 1;
  localparam int ST_T2 = ST_T1 + 1;
  localparam int ST_R1 = ST_T2 + 1;

  typedef struct packed {
    logic [FLD_W-1:0] val;
    logic             clip;
  } sat_t;

  function automatic sat_t sat_out(input logic signed [R_W-1:0] v);
    logic signed [R_W-1:0] hi;
    logic signed [R_W-1:0] lo;
    sat_t res;
    hi = R_W'(2 ** (OUT_W - 1) - 1);
    lo = -hi - R_W'(1);
    res.clip = 1'b0;
    res.val  = v[FLD_W-1:0];
    if (v > hi) begin
      res.val  = hi[FLD_W-1:0];
      res.clip = 1'b1;
    end else if (v < lo) begin
      res.val  = lo[FLD_W-1:0];
      res.clip = 1'b1;
    end
    return res;
  endfunction

endpackage

/* rtl/core/axis_angle_vector_rotate.sv */
// Axis-angle vector rotator, fully pipelined: square root, long division,
// CORDIC and quaternion products in one register chain. Uses avr_pkg.
//
// Usage:
//   s_axis carries one transaction per vector: binary angle (2^16 = one
//   turn), a Q1.14 axis of any length and a Q7.8 vector. m_axis returns the
//   rotated Q7.8 vector, saturated, with zero_axis and saturated in tuser.
//   From the input transaction to m_axis_tvalid: after the input register
//   come a squaring stage, 24 square-root stages (one root bit each), 31
//   divider stages (one quotient bit each), five multiply/round stages and
//   the output register. The CORDIC runs beside the square root.
//   Throughput is one transaction per cycle unless the receiver stalls.
//   A zero axis sets zero_axis and passes the vector through.
//   Reset clears all valid bits, m_axis_tvalid included; payload is not
//   cleared. When the receiver stalls, the whole chain holds once its last
//   stage has an item that cannot enter the output register; until then
//   empty slots keep moving and s_axis_tready stays high.
module axis_angle_vector_rotate
  import avr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // angle, axis_x, axis_y, axis_z, vec_x, vec_y, vec_z
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // out_x, out_y, out_z
  output logic [OUT_DW-1:0] m_axis_tdata,
  // zero_axis, saturated
  output logic [1:0]        m_axis_tuser
);

  logic adv;
  logic vld [0:ST_R1];

  // stage 0
  logic [FLD_W-1:0]        in_angle;
  logic signed [FLD_W-1:0] in_a [3];
  logic signed [FLD_W-1:0] in_v [3];

  // stage 1 inputs
  logic signed [SUM_W-1:0] sq [3];
  logic [SUM_W-1:0]        sum;
  logic [FLD_W-1:0]        mag [3];

  // square root chain
  logic [N_W-1:0]    sq_n   [0:NSQ-1];
  logic [FLD_W-1:0]  sq_mag [0:NSQ][3];
  logic [LEN_W+1:0]  sq_r   [1:NSQ-1];
  logic [LEN_W-1:0]  sq_q   [1:NSQ];

  // divider chain
  logic [LEN_W-1:0] dv_r   [1:NDV-1][3];
  logic [LEN_W-1:0] dv_len [1:NDV-1];
  logic [NDV-1:0]   dv_q   [1:NDV][3];

  // CORDIC chain
  logic signed [CS_W-1:0] cx [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] cy [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] cz [0:CORDIC_STAGES];
  logic                   ct [0:CORDIC_STAGES];
  logic signed [CS_W-1:0] xc, yc;
  logic signed [CS_W-1:0] cs_c [ST_CS:ST_T2];
  logic signed [CS_W-1:0] cs_s [ST_CS:ST_DV];

  // carried fields
  logic                    sign_d [1:ST_DV][3];
  logic                    zero_d [1:ST_R1];
  logic signed [FLD_W-1:0] vec_d  [1:ST_R1][3];

  // quaternion and products
  logic signed [CS_W-1:0] u   [3];
  logic signed [PQ_W-1:0] pm  [3];
  logic signed [CS_W-1:0] q_d [ST_Q:ST_T2][3];
  logic signed [PT_W-1:0] pt  [12];
  logic signed [ST_W-1:0] st  [4];
  logic signed [T_W-1:0]  t   [4];
  logic signed [PR_W-1:0] pr  [12];
  logic signed [SR_W-1:0] sr  [3];
  logic signed [R_W-1:0]  rv  [3];
  sat_t                   so  [3];

  // output register
  logic [FLD_W-1:0] out_c [3];
  logic             out_zero;
  logic             out_sat;

  assign adv           = !vld[ST_R1] || !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= ST_R1; i++) begin
        vld[i] <= 1'b0;
      end
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        vld[0] <= s_axis_tvalid;
        for (int i = 1; i <= ST_R1; i++) begin
          vld[i] <= vld[i-1];
        end
      end
      if (adv && vld[ST_R1]) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // stage 1: squares, magnitudes, CORDIC start
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq[c]  = in_a[c] * in_a[c];
      mag[c] = in_a[c][FLD_W-1] ? FLD_W'(-in_a[c]) : in_a[c];
    end
    sum = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_angle <= s_axis_tdata[FLD_W-1:0];
      for (int c = 0; c < 3; c++) begin
        in_a[c] <= s_axis_tdata[FLD_W*(1+c) +: FLD_W];
        in_v[c] <= s_axis_tdata[FLD_W*(4+c) +: FLD_W];
      end

      sq_n[0] <= {sum, 16'd0};
      zero_d[1] <= (sum == '0);
      for (int c = 0; c < 3; c++) begin
        sq_mag[0][c] <= mag[c];
        sign_d[1][c] <= in_a[c][FLD_W-1];
        vec_d[1][c]  <= in_v[c];
      end
      cx[0] <= INV_GAIN;
      cy[0] <= '0;
      cz[0] <= {2'b00, in_angle[FLD_W-2:0], 15'd0};
      ct[0] <= in_angle[FLD_W-1];

      // carried fields
      for (int i = 2; i <= ST_DV; i++) begin
        sign_d[i] <= sign_d[i-1];
      end
      for (int i = 2; i <= ST_R1; i++) begin
        zero_d[i] <= zero_d[i-1];
        vec_d[i]  <= vec_d[i-1];
      end
    end
  end

  // square root, one root bit per stage
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int P = NSQ - 1 - j;
    logic [LEN_W+1:0] r_in;
    logic [LEN_W-1:0] q_in;
    logic [LEN_W+3:0] rr;
    logic [LEN_W+1:0] tt;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = sq_r[j];
      assign q_in = sq_q[j];
    end

    assign rr = {r_in, sq_n[j][2*P+1:2*P]};
    assign tt = {q_in, 2'b01};
    assign ge = (rr >= {2'b00, tt});

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_q[j+1]   <= {q_in[LEN_W-2:0], ge};
        sq_mag[j+1] <= sq_mag[j];
      end
    end

    if (j + 1 < NSQ) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_r[j+1] <= ge ? (LEN_W+2)'(rr - {2'b00, tt}) : (LEN_W+2)'(rr);
          sq_n[j+1] <= sq_n[j];
        end
      end
    end
  end

  // restoring division, one quotient bit per stage for each component
  for (genvar k = 0; k < NDV; k++) begin : g_div
    logic [LEN_W-1:0] r_in [3];
    logic [LEN_W-1:0] len_in;
    logic [NDV-1:0]   q_in [3];
    logic [LEN_W:0]   rr   [3];
    logic             ge   [3];

    if (k == 0) begin : g_first
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          r_in[c] = LEN_W'({sq_mag[NSQ][c], {DV_PRE{1'b0}}});
          q_in[c] = '0;
        end
      end
      assign len_in = sq_q[NSQ];
    end else begin : g_next
      always_comb begin
        for (int c = 0; c < 3; c++) begin
          r_in[c] = dv_r[k][c];
          q_in[c] = dv_q[k][c];
        end
      end
      assign len_in = dv_len[k];
    end

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        rr[c] = {r_in[c], 1'b0};
        ge[c] = (rr[c] >= {1'b0, len_in});
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int c = 0; c < 3; c++) begin
          dv_q[k+1][c] <= {q_in[c][NDV-2:0], ge[c]};
        end
      end
    end

    if (k + 1 < NDV) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_len[k+1] <= len_in;
          for (int c = 0; c < 3; c++) begin
            dv_r[k+1][c] <= ge[c] ? LEN_W'(rr[c] - {1'b0, len_in}) : LEN_W'(rr[c]);
          end
        end
      end
    end
  end

  // CORDIC rotation stages on the half angle
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        ct[i+1] <= ct[i];
        if (!cz[i][CS_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_TBL[i];
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_TBL[i];
        end
      end
    end
  end

  always_comb begin
    xc = cx[CORDIC_STAGES];
    yc = cy[CORDIC_STAGES];
    if (xc > QUARTER) xc = QUARTER;
    if (xc < -QUARTER) xc = -QUARTER;
    if (yc > QUARTER) yc = QUARTER;
    if (yc < -QUARTER) yc = -QUARTER;
  end

  // clamp, undo the quarter-turn offset, then hold cos/sin alongside the item
  always_ff @(posedge clk) begin
    if (adv) begin
      cs_c[ST_CS] <= ct[CORDIC_STAGES] ? -yc : xc;
      cs_s[ST_CS] <= ct[CORDIC_STAGES] ? xc : yc;
      for (int i = ST_CS + 1; i <= ST_T2; i++) begin
        cs_c[i] <= cs_c[i-1];
      end
      for (int i = ST_CS + 1; i <= ST_DV; i++) begin
        cs_s[i] <= cs_s[i-1];
      end
    end
  end

  // quaternion vector part and the two Hamilton products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      u[c] = sign_d[ST_DV][c] ? -$signed({1'b0, dv_q[NDV][c]})
                              :  $signed({1'b0, dv_q[NDV][c]});
    end

    st[0] = -(ST_W'(pt[0]) + ST_W'(pt[1]) + ST_W'(pt[2]));
    st[1] = ST_W'(pt[3]) + ST_W'(pt[6]) - ST_W'(pt[7]);
    st[2] = ST_W'(pt[4]) + ST_W'(pt[8]) - ST_W'(pt[9]);
    st[3] = ST_W'(pt[5]) + ST_W'(pt[10]) - ST_W'(pt[11]);

    sr[0] = -SR_W'(pr[0]) + SR_W'(pr[1]) - SR_W'(pr[2]) + SR_W'(pr[3]);
    sr[1] = -SR_W'(pr[4]) + SR_W'(pr[5]) - SR_W'(pr[6]) + SR_W'(pr[7]);
    sr[2] = -SR_W'(pr[8]) + SR_W'(pr[9]) - SR_W'(pr[10]) + SR_W'(pr[11]);

    for (int c = 0; c < 3; c++) begin
      if (zero_d[ST_R1]) begin
        rv[c] = R_W'(vec_d[ST_R1][c]);
      end else begin
        rv[c] = R_W'((sr[c] + (SR_W'(1) <<< 37)) >>> 38);
      end
      so[c] = sat_out(rv[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // M1: s * u
      for (int c = 0; c < 3; c++) begin
        pm[c] <= cs_s[ST_DV] * u[c];
      end
      // Q: round to Q2.30
      for (int c = 0; c < 3; c++) begin
        q_d[ST_Q][c] <= CS_W'((pm[c] + (PQ_W'(1) <<< 29)) >>> 30);
      end
      for (int i = ST_Q + 1; i <= ST_T2; i++) begin
        q_d[i] <= q_d[i-1];
      end
      // T1: q * p products
      pt[0]  <= q_d[ST_Q][0] * vec_d[ST_Q][0];
      pt[1]  <= q_d[ST_Q][1] * vec_d[ST_Q][1];
      pt[2]  <= q_d[ST_Q][2] * vec_d[ST_Q][2];
      pt[3]  <= cs_c[ST_Q] * vec_d[ST_Q][0];
      pt[4]  <= cs_c[ST_Q] * vec_d[ST_Q][1];
      pt[5]  <= cs_c[ST_Q] * vec_d[ST_Q][2];
      pt[6]  <= q_d[ST_Q][1] * vec_d[ST_Q][2];
      pt[7]  <= q_d[ST_Q][2] * vec_d[ST_Q][1];
      pt[8]  <= q_d[ST_Q][2] * vec_d[ST_Q][0];
      pt[9]  <= q_d[ST_Q][0] * vec_d[ST_Q][2];
      pt[10] <= q_d[ST_Q][0] * vec_d[ST_Q][1];
      pt[11] <= q_d[ST_Q][1] * vec_d[ST_Q][0];
      // T2: round to Q16
      for (int i = 0; i < 4; i++) begin
        t[i] <= T_W'((st[i] + (ST_W'(1) <<< 21)) >>> 22);
      end
      // R1: (q * p) * conj(q) products
      pr[0]  <= t[0] * q_d[ST_T2][0];
      pr[1]  <= t[1] * cs_c[ST_T2];
      pr[2]  <= t[2] * q_d[ST_T2][2];
      pr[3]  <= t[3] * q_d[ST_T2][1];
      pr[4]  <= t[0] * q_d[ST_T2][1];
      pr[5]  <= t[2] * cs_c[ST_T2];
      pr[6]  <= t[3] * q_d[ST_T2][0];
      pr[7]  <= t[1] * q_d[ST_T2][2];
      pr[8]  <= t[0] * q_d[ST_T2][2];
      pr[9]  <= t[3] * cs_c[ST_T2];
      pr[10] <= t[1] * q_d[ST_T2][1];
      pr[11] <= t[2] * q_d[ST_T2][0];
    end
    // output register: round to Q8, pass through on zero axis, saturate
    if (adv && vld[ST_R1]) begin
      for (int c = 0; c < 3; c++) begin
        out_c[c] <= so[c].val;
      end
      out_zero <= zero_d[ST_R1];
      out_sat  <= so[0].clip || so[1].clip || so[2].clip;
    end
  end

  assign m_axis_tdata = {out_c[2], out_c[1], out_c[0]};
  assign m_axis_tuser = {out_sat, out_zero};

  a_ready_follows: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while receiver ready");

  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_R1] && adv) |=> m_axis_tvalid)
    else $error("finished item did not reach output register");

  a_zero_no_clip: assert property (@(posedge clk) disable iff (rst)
    (OUT_W == FLD_W) && m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
    else $error("pass-through vector flagged as clipped");

endmodule

/* tb/axis_angle_vector_rotate_tb.sv */
// Self-checking bench for axis_angle_vector_rotate: random and directed rotations
// checked against an in-bench fixed-point predictor. Depends on avr_pkg and the RTL.
module axis_angle_vector_rotate_tb;
  import avr_pkg::*;

  localparam int  LIMIT      = 600000;
  localparam int  N_RANDOM   = 1700;
  localparam int  LATENCY    = ST_R1 + 1;
  localparam longint QTURN   = 64'sd1073741824;
  localparam longint GAIN0   = 64'sd652032874;
  localparam logic [15:0] Z16 = 16'h0000;

  typedef struct {
    logic [15:0] angle;
    logic signed [15:0] ax, ay, az, vx, vy, vz;
  } rot_in_t;

  typedef struct {
    logic [15:0] x, y, z;
    logic        zero_axis;
    logic        clipped;
  } rot_out_t;

  class rotation_scoreboard;
    rot_out_t expected_q[$];
    int errors;
    int checked;
    int zero_seen;
    int clip_seen;

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp_q30(longint v);
      if (v > QTURN) return QTURN;
      if (v < -QTURN) return -QTURN;
      return v;
    endfunction

    function longint unit_axis(longint a, longint unsigned len);
      longint unsigned mag;
      longint q;
      mag = longint'(a < 0 ? -a : a) << 38;
      q = longint'(mag / len);
      return a < 0 ? -q : q;
    endfunction

    function logic [15:0] clip16(longint v, ref logic flag);
      if (v > 32767) begin
        flag = 1'b1;
        return 16'h7fff;
      end
      if (v < -32768) begin
        flag = 1'b1;
        return 16'h8000;
      end
      return v[15:0];
    endfunction

    // predict one rotation and queue it
    function void note_input(rot_in_t it);
      longint ax, ay, az, vx, vy, vz, h, z, cx, cy, dx, dy, c, s;
      longint qx, qy, qz, tw, tx, ty, tz, rx, ry, rz;
      longint unsigned sum, len;
      logic turned, flag;
      rot_out_t r;
      ax = it.ax; ay = it.ay; az = it.az;
      vx = it.vx; vy = it.vy; vz = it.vz;
      sum = longint'(ax * ax + ay * ay + az * az);
      flag = 1'b0;
      if (sum == 0) begin
        rx = vx; ry = vy; rz = vz;
        r.zero_axis = 1'b1;
      end else begin
        len = int_sqrt(sum << 16);
        h = longint'(it.angle) << 15;
        turned = h >= QTURN;
        z = turned ? h - QTURN : h;
        cx = GAIN0;
        cy = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (z >= 0) begin
            cx -= dx; cy += dy; z -= longint'(ATAN_TBL[i]);
          end else begin
            cx += dx; cy -= dy; z += longint'(ATAN_TBL[i]);
          end
        end
        cx = clamp_q30(cx);
        cy = clamp_q30(cy);
        if (turned) begin
          c = -cy; s = cx;
        end else begin
          c = cx; s = cy;
        end
        qx = round_shift(s * unit_axis(ax, len), 30);
        qy = round_shift(s * unit_axis(ay, len), 30);
        qz = round_shift(s * unit_axis(az, len), 30);
        tw = round_shift(-qx * vx - qy * vy - qz * vz, 22);
        tx = round_shift(c * vx + qy * vz - qz * vy, 22);
        ty = round_shift(c * vy + qz * vx - qx * vz, 22);
        tz = round_shift(c * vz + qx * vy - qy * vx, 22);
        rx = round_shift(-tw * qx + tx * c - ty * qz + tz * qy, 38);
        ry = round_shift(-tw * qy + ty * c - tz * qx + tx * qz, 38);
        rz = round_shift(-tw * qz + tz * c - tx * qy + ty * qx, 38);
        r.zero_axis = 1'b0;
      end
      r.x = clip16(rx, flag);
      r.y = clip16(ry, flag);
      r.z = clip16(rz, flag);
      r.clipped = flag;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_result(rot_out_t got);
      rot_out_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result, out_x", got.x, 16'h0000);
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x) report("out_x", got.x, want.x);
        if (got.y !== want.y) report("out_y", got.y, want.y);
        if (got.z !== want.z) report("out_z", got.z, want.z);
        if (got.zero_axis !== want.zero_axis)
          report("zero_axis", 16'(got.zero_axis), 16'(want.zero_axis));
        if (got.clipped !== want.clipped)
          report("saturated", 16'(got.clipped), 16'(want.clipped));
        if (want.zero_axis) zero_seen++;
        if (want.clipped) clip_seen++;
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DW-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  rotation_scoreboard board = new();
  int  cycles = 0;
  bit  hold_request = 1'b0;
  int  sent = 0;

  axis_angle_vector_rotate dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // monitor: sample completed output transactions
  always @(posedge clk) begin
    rot_out_t r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      r.x = m_axis_tdata[15:0];
      r.y = m_axis_tdata[31:16];
      r.z = m_axis_tdata[47:32];
      r.zero_axis = m_axis_tuser[0];
      r.clipped = m_axis_tuser[1];
      board.check_result(r);
    end
  end

  function int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        gap = (sent % 600 < 150) ? 0 : pick_gap();
        if (gap == 0) begin
          m_axis_tready = 1'b1;
          @(negedge clk);
        end else begin
          m_axis_tready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  task send_rotation(rot_in_t it, int gap);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata = {it.vz, it.vy, it.vx, it.az, it.ay, it.ax, it.angle};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    board.note_input(it);
    sent++;
    @(negedge clk);
  endtask

  function logic [15:0] pick_axis();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 16'h0000;
    if (p == 1) return 16'h8000;
    if (p == 2) return 16'h7fff;
    if (p == 3) return 16'(16'sd16384);
    if (p == 4) return 16'(-16'sd16384);
    return rand16();
  endfunction

  function rot_in_t make_rotation(logic [15:0] ang, logic [15:0] ax, logic [15:0] ay,
                                  logic [15:0] az, logic [15:0] vx, logic [15:0] vy,
                                  logic [15:0] vz);
    rot_in_t it;
    it.angle = ang;
    it.ax = ax; it.ay = ay; it.az = az;
    it.vx = vx; it.vy = vy; it.vz = vz;
    return it;
  endfunction

  initial begin
    rot_in_t it;
    int drain;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // directed: angle extremes, axis extremes, zero axis, clipping
    send_rotation(make_rotation(16'h0000, 16'h4000, Z16, Z16,
                                16'h0100, 16'h0200, 16'h0300), 0);
    send_rotation(make_rotation(16'h4000, Z16, Z16, 16'h4000, 16'h0100, Z16, Z16), 0);
    send_rotation(make_rotation(16'h8000, Z16, 16'h4000, Z16,
                                16'h0100, 16'h0100, 16'h0100), 0);
    send_rotation(make_rotation(16'hc000, 16'h4000, Z16, Z16, Z16, 16'h0100, Z16), 0);
    send_rotation(make_rotation(16'hffff, 16'h7fff, 16'h7fff, 16'h7fff,
                                16'h7fff, 16'h8000, 16'h7fff), 0);
    send_rotation(make_rotation(16'h2000, 16'h8000, 16'h8000, 16'h8000,
                                16'h7fff, 16'h7fff, 16'h7fff), 0);
    send_rotation(make_rotation(16'h1234, Z16, Z16, Z16, 16'h8000, 16'h7fff, 16'h0001), 0);
    send_rotation(make_rotation(16'hffff, Z16, Z16, Z16, 16'hffff, Z16, 16'h8000), 1);
    send_rotation(make_rotation(16'h2000, Z16, Z16, 16'h0001, 16'h7fff, 16'h7fff, Z16), 0);
    send_rotation(make_rotation(16'h4000, 16'h0001, 16'hffff, Z16,
                                16'h8000, 16'h8000, 16'h8000), 2);
    send_rotation(make_rotation(16'h7fff, 16'h8000, Z16, Z16,
                                16'h1234, 16'hedcb, 16'h0f0f), 0);
    send_rotation(make_rotation(16'h8001, Z16, 16'h7fff, Z16, 16'h5555, 16'haaaa, Z16), 0);
    send_rotation(make_rotation(16'h6000, 16'h0100, 16'h0100, 16'h0100,
                                16'h7fff, Z16, 16'h8000), 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      // one long receiver hold-off while input keeps coming
      if (n == 500) hold_request = 1'b1;
      if ($urandom_range(0, 19) == 0)
        it = make_rotation(rand16(), Z16, Z16, Z16, rand16(), rand16(), rand16());
      else
        it = make_rotation(rand16(), pick_axis(), pick_axis(), pick_axis(),
                           rand16(), rand16(), rand16());
      send_rotation(it, (n >= 450 && n < 900) ? 0 : pick_gap());
    end
    s_axis_tvalid = 1'b0;

    drain = 0;
    while (board.expected_q.size() != 0) @(negedge clk);
    while (drain < 2 * LATENCY) begin
      @(negedge clk);
      drain++;
    end

    $display("checked %0d rotations: %0d with zero axis, %0d clipped",
             board.checked, board.zero_seen, board.clip_seen);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/core/avr_pkg.sv
rtl/core/axis_angle_vector_rotate.sv
tb/axis_angle_vector_rotate_tb.sv
